### design/rcls_pkg.sv
// Shared types and constants for the rotating circular list store.
// Holds widths, command and status codes, the sequencer state type and the
// request/response structs of the remainder unit. No dependencies.
`default_nettype none

package rcls_pkg;

    // Storage size and derived widths
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 12;
    localparam int VAL_W    = 32;
    localparam int ROT_W    = 13;
    localparam int TOTAL_W  = 9;
    localparam int STAT_W   = 2;

    // Remainder unit: dividend wide enough for a rotate magnitude of 4096
    localparam int DVD_W    = ROT_W;
    localparam int STEP_W   = $clog2(DVD_W + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SHIFT,
        S_WRITE,
        S_GET_RD,
        S_GET_DATA,
        S_RM_FIN,
        S_DONE
    } state_t;

    // Remainder unit handshake
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

### design/rcls_if.sv
// Channel interfaces of the list store: command channel and result channel.
// Each carries valid, ready and the payload. Depends on rcls_pkg.
`default_nettype none

interface rcls_req_if;
    import rcls_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] write_value;
    logic signed [ROT_W-1:0] rotate_amount;

    modport source (output valid, cmd, position, write_value, rotate_amount, input ready);
    modport sink   (input valid, cmd, position, write_value, rotate_amount, output ready);
endinterface

interface rcls_rsp_if;
    import rcls_pkg::*;

    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   read_value;
    logic [TOTAL_W-1:0] entry_total;
    logic [STAT_W-1:0]  status;

    modport source (output valid, read_value, entry_total, status, input ready);
    modport sink   (input valid, read_value, entry_total, status, output ready);
endinterface

`default_nettype wire

### design/rotating_circular_list_store_top.sv
// Top level of the rotating circular list store: command sequencer, entry
// RAM and remainder unit. Depends on rcls_pkg, rcls_if, rcls_ram, rcls_mod.
//
// Usage:
//   req carries one command per transfer (get, set, insert, remove, rotate);
//   rsp returns exactly one result per command: read value, entry count
//   after the command, and status (ok, list empty, list full).
//   req.ready is high only while the sequencer is idle; one command is in
//   work at a time.
// Flow: an unused code or an error goes straight to the result step. Get,
//   set, rotate, remove and an insert at a nonzero position into a non-empty
//   list first run the 13-step remainder unit; insert and remove then move
//   the stored words, one word per cycle through the single RAM port pair.
// Reset: the list is empty, head at zero, no result pending. The RAM is not
//   cleared; only written entries are ever read.
// Stall: a finished result sits in the output register until rsp.ready;
//   the next command is accepted meanwhile and waits for that register
//   before its own result is loaded.
`default_nettype none

module rotating_circular_list_store_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rcls_req_if.sink   req,
    rcls_rsp_if.source rsp
);
    import rcls_pkg::*;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic               neg_reg, neg_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]  wb_addr_reg, wb_addr_next;
    logic [VAL_W-1:0]   rd_reg, rd_next;
    logic [STAT_W-1:0]  st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_value_reg, out_value_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    logic [ROT_W-1:0]   rot_mag;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   slot;
    logic [SUM_W-1:0]   back;
    logic [CNT_W-1:0]   ins_q;
    logic [CNT_W-1:0]   cnt_dec;
    logic [ADDR_W-1:0]  rm_head;

    // Entry storage and shared remainder unit
    rcls_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcls_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Rotate magnitude from the signed amount
    assign rot_mag = req.rotate_amount[ROT_W-1] ? ROT_W'(-req.rotate_amount)
                                                 : ROT_W'(req.rotate_amount);

    // Store index from the remainder: head + rem, wrapped once
    always_comb
    begin
        sum = SUM_W'(head_reg) + SUM_W'(mod_rsp.remainder);
        if (sum >= SUM_W'(count_reg))
        begin
            slot = CNT_W'(sum - SUM_W'(count_reg));
        end
        else
        begin
            slot = CNT_W'(sum);
        end
        back  = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(mod_rsp.remainder);
        ins_q = slot + 1'b1;
    end

    // Head after remove
    always_comb
    begin
        cnt_dec = count_reg - 1'b1;
        rm_head = head_reg;
        if (addr_reg < CNT_W'(head_reg))
        begin
            rm_head = head_reg - 1'b1;
        end
        if (cnt_dec == '0 || CNT_W'(rm_head) >= cnt_dec)
        begin
            rm_head = '0;
        end
    end

    // RAM read address: shift pointer while moving words, else the target
    assign ram_raddr = (state_reg == S_SHIFT) ? ptr_reg : ADDR_W'(addr_reg);

    // Sequencer: next state, datapath updates, RAM and divider control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        neg_next        = neg_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = wb_addr_reg;
        rd_next         = rd_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_total_next  = out_total_reg;
        out_status_next = out_status_reg;

        // Pending write of a word read in the previous cycle
        ram_we    = wb_valid_reg;
        ram_waddr = wb_addr_reg;
        ram_wdata = ram_rdata;

        mod_req.start    = 1'b0;
        mod_req.divisor  = count_reg;
        mod_req.dividend = DVD_W'(req.position);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.cmd;
                    val_next = req.write_value;
                    neg_next = req.rotate_amount[ROT_W-1];
                    rd_next  = '0;
                    st_next  = ST_OK;
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            addr_next  = '0;
                            head_next  = '0;
                            state_next = S_WRITE;
                        end
                        else if (req.position == '0)
                        begin
                            // New value takes the head slot
                            addr_next  = CNT_W'(head_reg);
                            left_next  = count_reg - CNT_W'(head_reg);
                            ptr_next   = ADDR_W'(count_reg - 1'b1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = DVD_W'(req.position - 1'b1);
                            state_next       = S_MOD;
                        end
                    end
                    else if (req.cmd > CMD_ROTATE)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mod_req.start = 1'b1;
                        if (req.cmd == CMD_ROTATE)
                        begin
                            mod_req.dividend = rot_mag;
                        end
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    case (cmd_reg)
                        CMD_ROTATE:
                        begin
                            if (neg_reg)
                            begin
                                if (back >= SUM_W'(count_reg))
                                begin
                                    head_next = ADDR_W'(back - SUM_W'(count_reg));
                                end
                                else
                                begin
                                    head_next = ADDR_W'(back);
                                end
                            end
                            else
                            begin
                                head_next = ADDR_W'(slot);
                            end
                            state_next = S_DONE;
                        end
                        CMD_GET:
                        begin
                            addr_next  = slot;
                            state_next = S_GET_RD;
                        end
                        CMD_SET:
                        begin
                            addr_next  = slot;
                            state_next = S_WRITE;
                        end
                        CMD_REMOVE:
                        begin
                            addr_next  = slot;
                            ptr_next   = ADDR_W'(slot + 1'b1);
                            left_next  = count_reg - 1'b1 - slot;
                            state_next = S_SHIFT;
                        end
                        CMD_INSERT:
                        begin
                            // Insert just after the entry at slot
                            addr_next = ins_q;
                            if (ins_q <= CNT_W'(head_reg))
                            begin
                                head_next = head_reg + 1'b1;
                            end
                            left_next  = count_reg - ins_q;
                            ptr_next   = ADDR_W'(count_reg - 1'b1);
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // One word per cycle: read now, write one slot over next cycle
                if (left_reg != '0)
                begin
                    wb_valid_next = 1'b1;
                    left_next     = left_reg - 1'b1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        wb_addr_next = ptr_reg + 1'b1;
                        ptr_next     = ptr_reg - 1'b1;
                    end
                    else
                    begin
                        wb_addr_next = ptr_reg - 1'b1;
                        ptr_next     = ptr_reg + 1'b1;
                    end
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_RM_FIN;
                end
            end

            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(addr_reg);
                ram_wdata = val_reg;
                if (cmd_reg == CMD_INSERT)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end

            S_GET_RD:
            begin
                state_next = S_GET_DATA;
            end

            S_GET_DATA:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end

            S_RM_FIN:
            begin
                count_next = cnt_dec;
                head_next  = rm_head;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_reg;
                    out_total_next  = TOTAL_W'(count_reg);
                    out_status_next = st_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        neg_reg        <= neg_next;
        addr_reg       <= addr_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        wb_addr_reg    <= wb_addr_next;
        rd_reg         <= rd_next;
        st_reg         <= st_next;
        out_value_reg  <= out_value_next;
        out_total_reg  <= out_total_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_total = out_total_reg;
    assign rsp.status      = out_status_reg;

`ifndef SYNTHESIS
    // Count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Between commands the head points inside the list, or at zero when empty
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            ((count_reg == '0) ? (head_reg == '0) : (CNT_W'(head_reg) < count_reg)))
        else $error("head outside the list");

    // One command in work at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second command taken while busy");

    // A new result appears only when the sequencer finishes a command
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the finish step");
`endif

endmodule

`default_nettype wire

### design/rcls_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rcls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/rcls_mod.sv
// Iterative remainder unit: dividend mod divisor, one dividend bit per cycle
// (restoring shift-subtract). Depends on rcls_pkg.
`default_nettype none

module rcls_mod (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rcls_pkg::mod_req_t req,
    output rcls_pkg::mod_rsp_t      rsp
);
    import rcls_pkg::*;

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  rem_next;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = CNT_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = CNT_W'(trial);
        end
    end

    // Control: run flag, step count, one-cycle done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### bench/rcls_checker.sv
// Reply checker for the rotating circular list store: watches both channels,
// keeps its own copy of the list and compares every reply in order.
// Depends on rcls_pkg and the channel interfaces in rcls_if.
module rcls_checker (
    input  logic       clk,
    input  logic       rst_n,
    rcls_req_if        req,
    rcls_rsp_if        rsp,
    output int         fail_count,
    output int         pending,
    output int         occupancy,
    output int         checked
);
    import rcls_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]   read_value;
        logic [TOTAL_W-1:0] entry_total;
        logic [STAT_W-1:0]  status;
    } list_reply_t;

    // Shadow list: dense word store, head slot and entry count
    logic [VAL_W-1:0] words [CAPACITY];
    int               head;
    int               count;

    list_reply_t      expected_replies [$];
    int               errors;
    int               compared;

    // Store slot holding logical position p; list must not be empty
    function automatic int slot_at(input int p);
        return (head + (p % count)) % count;
    endfunction

    // Apply one command to the shadow list and return the reply it yields
    function automatic list_reply_t apply_list_command(
        input logic [CMD_W-1:0] op,
        input logic [POS_W-1:0] pos,
        input logic [VAL_W-1:0] val,
        input logic [ROT_W-1:0] rot
    );
        list_reply_t r;
        int          q;
        int          i;
        int          mag;
        int          step;
        r = '0;
        case (op)
            CMD_INSERT:
            begin
                if (count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else if (count == 0)
                begin
                    words[0] = val;
                    head     = 0;
                    count    = 1;
                end
                else
                begin
                    // position zero takes the head slot, others go after pos-1
                    if (pos == '0)
                    begin
                        q = head;
                    end
                    else
                    begin
                        q = slot_at(int'(pos) - 1) + 1;
                        if (q <= head)
                            head++;
                    end
                    for (i = count; i > q; i--)
                        words[i] = words[i-1];
                    words[q] = val;
                    count++;
                end
            end
            CMD_GET, CMD_SET, CMD_REMOVE, CMD_ROTATE:
            begin
                if (count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    case (op)
                        CMD_GET:
                            r.read_value = words[slot_at(int'(pos))];
                        CMD_SET:
                            words[slot_at(int'(pos))] = val;
                        CMD_REMOVE:
                        begin
                            q = slot_at(int'(pos));
                            for (i = q; i + 1 < count; i++)
                                words[i] = words[i+1];
                            count--;
                            if (q < head)
                                head--;
                            if (count == 0 || head >= count)
                                head = 0;
                        end
                        default:
                        begin
                            // rotate by magnitude mod count, direction by sign
                            mag  = rot[ROT_W-1] ? (1 << ROT_W) - int'(rot) : int'(rot);
                            step = mag % count;
                            if (rot[ROT_W-1])
                                head = (head + count - step) % count;
                            else
                                head = (head + step) % count;
                        end
                    endcase
                end
            end
            default:
            begin
                // unused codes leave the list alone
            end
        endcase
        r.entry_total = TOTAL_W'(count);
        return r;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH %s", msg);
    endtask

    // Predict on each command transfer, compare on each reply transfer
    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t want;
        if (!rst_n)
        begin
            head     = 0;
            count    = 0;
            errors   = 0;
            compared = 0;
            expected_replies.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                expected_replies.push_back(apply_list_command(req.cmd, req.position,
                    req.write_value, req.rotate_amount));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    report($sformatf("reply with no command outstanding: %08h %0d %0d",
                        rsp.read_value, rsp.entry_total, rsp.status));
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report($sformatf("reply %0d read_value: expected %08h, got %08h",
                            compared, want.read_value, rsp.read_value));
                    if (rsp.entry_total !== want.entry_total)
                        report($sformatf("reply %0d entry_total: expected %0d, got %0d",
                            compared, want.entry_total, rsp.entry_total));
                    if (rsp.status !== want.status)
                        report($sformatf("reply %0d status: expected %0d, got %0d",
                            compared, want.status, rsp.status));
                end
                compared++;
            end
        end
        fail_count <= errors;
        pending    <= expected_replies.size();
        occupancy  <= count;
        checked    <= compared;
    end

endmodule

### bench/testbench.sv
// Top of the list store bench: clock, reset, command and reply stimulus with
// random idling, watchdog and verdict. Depends on rcls_pkg, rcls_if,
// rotating_circular_list_store_top and rcls_checker.
module testbench;
    import rcls_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic clk;
    logic rst_n;

    rcls_req_if req_if();
    rcls_rsp_if rsp_if();

    int fail_count;
    int pending;
    int occupancy;
    int checked;

    // Command mix tallies for the summary
    int sent;
    int n_insert;
    int n_remove;
    int n_rotate;
    int n_access;
    int n_unused;
    bit calm;

    rotating_circular_list_store_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    rcls_checker reply_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending),
        .occupancy  (occupancy),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, POS_MAX);
        if (r < 8)
            return $urandom_range(0, occupancy);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return POS_MAX;
            default: return occupancy;
        endcase
    endfunction

    function automatic int pick_rot();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0: return 4095;
                1: return -4096;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
        end
        if (r < 6)
            return $urandom_range(0, 2 * occupancy + 2) - (occupancy + 1);
        return $urandom_range(0, 8191) - 4096;
    endfunction

    // One command transfer, then an optional idle gap
    task automatic send_cmd(input logic [CMD_W-1:0] op, input int pos,
                            input logic [VAL_W-1:0] val, input int rot);
        int gap;
        if (sent % 16 == 0)
            calm = ($urandom_range(0, 3) == 0);
        req_if.valid         <= 1'b1;
        req_if.cmd           <= op;
        req_if.position      <= pos[POS_W-1:0];
        req_if.write_value   <= val;
        req_if.rotate_amount <= rot[ROT_W-1:0];
        do
            @(posedge clk);
        while (!req_if.ready);
        sent++;
        case (op)
            CMD_INSERT: n_insert++;
            CMD_REMOVE: n_remove++;
            CMD_ROTATE: n_rotate++;
            CMD_GET, CMD_SET: n_access++;
            default: n_unused++;
        endcase
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random command with random don't-care fields
    task automatic send_random(input int w_insert, input int w_remove);
        int               r;
        logic [CMD_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < w_insert)
            op = CMD_INSERT;
        else if (r < w_insert + w_remove)
            op = CMD_REMOVE;
        else if (r < w_insert + w_remove + 14)
            op = CMD_GET;
        else if (r < w_insert + w_remove + 24)
            op = CMD_SET;
        else if (r < 95)
            op = CMD_ROTATE;
        else
            op = CMD_GET + 3'($urandom_range(5, 7));
        send_cmd(op, pick_pos(), $urandom, pick_rot());
    endtask

    // Reply side: ready runs of random length with gaps between
    initial
    begin : reply_stall
        int run;
        int gap;
        forever
        begin
            rsp_if.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        sent     = 0;
        n_insert = 0;
        n_remove = 0;
        n_rotate = 0;
        n_access = 0;
        n_unused = 0;
        calm     = 1'b0;
        rst_n    = 1'b0;
        req_if.valid         <= 1'b0;
        req_if.cmd           <= CMD_GET;
        req_if.position      <= '0;
        req_if.write_value   <= '0;
        req_if.rotate_amount <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every access flags an error; unused codes are ignored
        send_cmd(CMD_GET,    0,       32'h0,        0);
        send_cmd(CMD_SET,    POS_MAX, 32'hFFFFFFFF, 0);
        send_cmd(CMD_REMOVE, 0,       32'h0,        0);
        send_cmd(CMD_ROTATE, 0,       32'h0,        1);
        send_cmd(CMD_GET + 3'd5, 0,   32'h0,        0);
        send_cmd(CMD_GET + 3'd6, POS_MAX, 32'hFFFFFFFF, -1);
        send_cmd(CMD_GET + 3'd7, POS_MAX, 32'hFFFFFFFF, -1);
        // First insert ignores position; head insert; append at count; wrap
        send_cmd(CMD_INSERT, POS_MAX, 32'hFFFFFFFF, 0);
        send_cmd(CMD_INSERT, 0,       32'h00000000, 0);
        send_cmd(CMD_INSERT, 2,       32'hA5A5A5A5, 0);
        send_cmd(CMD_INSERT, POS_MAX, 32'h5A5A5A5A, 0);
        send_cmd(CMD_INSERT, 1,       32'h12345678, 0);
        // Position taken modulo count
        send_cmd(CMD_GET,    0,       32'h0,        0);
        send_cmd(CMD_GET,    POS_MAX, 32'h0,        0);
        send_cmd(CMD_SET,    POS_MAX, 32'h0,        0);
        // Rotation extremes in both directions and zero
        send_cmd(CMD_ROTATE, 0,       32'h0,        4095);
        send_cmd(CMD_ROTATE, 0,       32'h0,        -4096);
        send_cmd(CMD_ROTATE, 0,       32'h0,        0);
        send_cmd(CMD_ROTATE, 0,       32'h0,        -1);
        send_cmd(CMD_GET,    1,       32'h0,        0);
        send_cmd(CMD_REMOVE, POS_MAX, 32'h0,        0);
        send_cmd(CMD_REMOVE, 0,       32'h0,        0);
        send_cmd(CMD_GET + 3'd7, 0,   32'h0,        0);
        send_cmd(CMD_GET,    2,       32'h0,        0);

        // Remove down to empty, then errors and a lone entry on the empty list
        while (occupancy > 0)
            send_cmd(CMD_REMOVE, pick_pos(), $urandom, pick_rot());
        send_cmd(CMD_REMOVE, pick_pos(), $urandom, pick_rot());
        send_cmd(CMD_ROTATE, pick_pos(), $urandom, pick_rot());
        send_cmd(CMD_GET,    pick_pos(), $urandom, pick_rot());
        send_cmd(CMD_INSERT, pick_pos(), $urandom, pick_rot());
        send_cmd(CMD_REMOVE, pick_pos(), $urandom, pick_rot());

        // Random mix that grows the list
        for (k = 0; k < 40; k++)
            send_random(34, 20);

        // Fill to capacity, then hit the full list
        while (occupancy < CAPACITY)
            send_cmd(CMD_INSERT, pick_pos(), $urandom, pick_rot());
        for (k = 0; k < 4; k++)
            send_cmd(CMD_INSERT, pick_pos(), $urandom, pick_rot());
        for (k = 0; k < 10; k++)
            send_random(10, 10);

        // Drain partway with some accesses in between
        while (occupancy > CAPACITY - 64)
        begin
            if ($urandom_range(0, 4) == 0)
                send_random(0, 0);
            else
                send_cmd(CMD_REMOVE, pick_pos(), $urandom, pick_rot());
        end

        // Tail of random traffic
        for (k = 0; k < 40; k++)
            send_random(40, 18);

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d commands: %0d inserts, %0d removes, %0d rotates,",
            sent, n_insert, n_remove, n_rotate);
        $display("%0d gets/sets, %0d unused, %0d replies checked; empty and full lists hit",
            n_access, n_unused, checked);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### rotating_circular_list_store_top.f
design/rcls_pkg.sv
design/rcls_if.sv
design/rcls_ram.sv
design/rcls_mod.sv
design/rotating_circular_list_store_top.sv
bench/rcls_checker.sv
bench/testbench.sv
